[sv/wbss_pkg.sv]
// ----------------------------------------------------------------------------
// wbss_pkg
// Shared types and constants for the wildcard byte signature search core:
// item and result payloads, register map and signature constants.
// ----------------------------------------------------------------------------
package wbss_pkg;

	localparam int PATTERN_REG_BYTES = 16;
	localparam logic [7:0] WILDCARD_BYTE = 8'h00;

	typedef enum logic [1:0] {
		REG_PATTERN_LOW    = 2'd0,
		REG_PATTERN_HIGH   = 2'd1,
		REG_PATTERN_LENGTH = 2'd2,
		REG_REGION_BASE    = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic        found;
		logic [63:0] match_address;
	} result_t;

endpackage

[sv/wildcard_byte_signature_search_core.sv]
// ----------------------------------------------------------------------------
// Path: the input register, one parallel window compare and the result
// register form the whole path. Throughput: one byte per cycle while the
// result register is not held by back-pressure (result_ready low).
// Reset: window, byte count, match flag and both stages clear; pattern 0,
// length 1, region base 0.
// ----------------------------------------------------------------------------
// wildcard_byte_signature_search_core
// Scans a byte stream for a wildcard signature and reports the address of
// the first match, or not found at the end of the region.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_search_core import wbss_pkg::*; #(
	parameter int MAX_PATTERN_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result
);

	localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

	logic [63:0]      pattern_low_q;
	logic [63:0]      pattern_high_q;
	logic [4:0]       pattern_length_q;
	logic [63:0]      region_base_q;
	reg_index_t       reg_index;
	logic             cfg_write;

	logic [MAX_PATTERN_BYTES-1:0][7:0] window_q;
	logic [MAX_PATTERN_BYTES-1:0][7:0] window_next;
	logic [63:0]      bytes_seen_q;
	logic [63:0]      seen_next;
	logic             match_reported_q;

	item_t            item_s1;
	logic             valid_s1;
	logic             advance;
	logic             hit;
	logic             full_match;
	logic             emit;
	logic [LEN_W-1:0] len_eff;
	logic [6:0]       len_ext;
	result_t          result_q;
	logic             result_valid_q;

	assign pready    = 1'b1;
	assign reg_index = reg_index_t'(paddr[4:3]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= 5'd1;
			region_base_q    <= '0;
		end else if (cfg_write) begin
			case (reg_index)
				REG_PATTERN_LOW:    pattern_low_q    <= pwdata;
				REG_PATTERN_HIGH:   pattern_high_q   <= pwdata;
				REG_PATTERN_LENGTH: pattern_length_q <= pwdata[4:0];
				REG_REGION_BASE:    region_base_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			REG_PATTERN_LOW:    prdata = pattern_low_q;
			REG_PATTERN_HIGH:   prdata = pattern_high_q;
			REG_PATTERN_LENGTH: prdata = {59'd0, pattern_length_q};
			REG_REGION_BASE:    prdata = region_base_q;
			default:            prdata = '0;
		endcase
	end

	// saturate length to 1..MAX_PATTERN_BYTES
	always_comb begin
		len_ext = {2'b00, pattern_length_q};
		if (len_ext == 7'd0) begin
			len_eff = LEN_W'(1);
		end else if (len_ext > 7'(MAX_PATTERN_BYTES)) begin
			len_eff = LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			len_eff = len_ext[LEN_W-1:0];
		end
	end

	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	wbss_match #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
		.LEN_W(LEN_W)
	) u_match (
		.window(window_q),
		.data_byte(item_s1.data_byte),
		.pattern({pattern_high_q, pattern_low_q}),
		.length(len_eff),
		.window_next(window_next),
		.hit(hit)
	);

	assign seen_next  = bytes_seen_q + 64'd1;
	assign full_match = !match_reported_q && (seen_next >= 64'(len_eff)) && hit;
	assign emit       = full_match || (!match_reported_q && item_s1.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q         <= '0;
			bytes_seen_q     <= '0;
			match_reported_q <= 1'b0;
		end else if (advance) begin
			if (item_s1.last_byte) begin
				window_q         <= '0;
				bytes_seen_q     <= '0;
				match_reported_q <= 1'b0;
			end else if (!match_reported_q) begin
				window_q         <= window_next;
				bytes_seen_q     <= seen_next;
				match_reported_q <= full_match;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= emit;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q.found <= full_match;
			if (full_match) begin
				result_q.match_address <= region_base_q + seen_next - 64'(len_eff);
			end else begin
				result_q.match_address <= '0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[sv/wbss_match.sv]
// ----------------------------------------------------------------------------
// wbss_match
// Shifts the next byte into the window and compares the updated window
// against the signature in parallel; zero signature bytes match anything.
// ----------------------------------------------------------------------------
module wbss_match import wbss_pkg::*; #(
	parameter int MAX_PATTERN_BYTES = 16,
	parameter int LEN_W = 5
) (
	input  logic [MAX_PATTERN_BYTES-1:0][7:0] window,
	input  logic [7:0]                        data_byte,
	input  logic [8*PATTERN_REG_BYTES-1:0]    pattern,
	input  logic [LEN_W-1:0]                  length,
	output logic [MAX_PATTERN_BYTES-1:0][7:0] window_next,
	output logic                              hit
);

	localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

	always_comb begin
		window_next[0] = data_byte;
		for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
			window_next[i] = window[i-1];
		end
	end

	always_comb begin
		logic [6:0]       idx_full;
		logic [IDX_W-1:0] idx;
		logic [7:0]       sig;
		hit = 1'b1;
		for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
			idx_full = (7'(length) - 7'd1 - 7'(j)) & 7'(MAX_PATTERN_BYTES - 1);
			idx = idx_full[IDX_W-1:0];
			if (j < PATTERN_REG_BYTES) begin
				sig = pattern[8*(j % PATTERN_REG_BYTES) +: 8];
			end else begin
				sig = WILDCARD_BYTE;
			end
			if ((7'(j) < 7'(length)) && (sig != WILDCARD_BYTE) &&
			    (sig != window_next[idx])) begin
				hit = 1'b0;
			end
		end
	end

endmodule

[dv/wbss_match_checker.sv]
// ----------------------------------------------------------------------------
// wbss_match_checker
// Watches the register port and both byte and result channels of the
// signature search core. It keeps its own copy of the signature registers,
// the byte window and the byte count, works out the result that each
// transferred byte causes, and compares every result transfer, field by
// field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module wbss_match_checker import wbss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        pready,
	input  logic        item_valid,
	input  logic        item_ready,
	input  item_t       item,
	input  logic        result_valid,
	input  logic        result_ready,
	input  result_t     result,
	output int          mismatches,
	output int          awaited
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_BYTES = 16;

	logic [127:0] signature;
	logic [4:0]   sig_length;
	logic [63:0]  base_address;
	logic [7:0]   window [WINDOW_BYTES];
	logic [63:0]  bytes_seen;
	logic         match_seen;
	result_t      expected_q [$];

	function automatic void clear_region();
		for (int i = 0; i < WINDOW_BYTES; i++) window[i] = '0;
		bytes_seen = '0;
		match_seen = 1'b0;
	endfunction

	task automatic scan_byte(input item_t in_item);
		int unsigned span;
		logic        hit;
		logic [7:0]  want;
		result_t     outcome;
		span = (sig_length == 5'd0) ? 1 :
		       (sig_length > WINDOW_BYTES) ? WINDOW_BYTES : sig_length;
		if (!match_seen) begin
			for (int i = WINDOW_BYTES - 1; i > 0; i--) window[i] = window[i - 1];
			window[0] = in_item.data_byte;
			bytes_seen = bytes_seen + 64'd1;
			hit = 1'b0;
			if (bytes_seen >= 64'(span)) begin
				hit = 1'b1;
				for (int j = 0; j < span; j++) begin
					want = signature[8*j +: 8];
					if (want != WILDCARD_BYTE && want != window[span - 1 - j])
						hit = 1'b0;
				end
			end
			if (hit) begin
				match_seen = 1'b1;
				outcome.found = 1'b1;
				outcome.match_address = base_address + (bytes_seen - 64'(span));
				expected_q.insert(expected_q.size(), outcome);
			end else if (in_item.last_byte) begin
				outcome = '0;
				expected_q.insert(expected_q.size(), outcome);
			end
		end
		if (in_item.last_byte)
			clear_region();
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t oldest;
		if (!arst_n) begin
			signature = '0;
			sig_length = 5'd1;
			base_address = '0;
			clear_region();
			expected_q.delete();
			mismatches = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_q.size() == 0) begin
					$error("result: unexpected transfer, found %0b match_address %h",
						result.found, result.match_address);
					mismatches++;
				end else begin
					oldest = expected_q.pop_front();
					if (result.found !== oldest.found) begin
						$error("found: expected %0b, actual %0b", oldest.found, result.found);
						mismatches++;
					end
					if (result.match_address !== oldest.match_address) begin
						$error("match_address: expected %h, actual %h",
							oldest.match_address, result.match_address);
						mismatches++;
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_index_t'(paddr[4:3]))
					REG_PATTERN_LOW:    signature[63:0]   = pwdata;
					REG_PATTERN_HIGH:   signature[127:64] = pwdata;
					REG_PATTERN_LENGTH: sig_length        = pwdata[4:0];
					REG_REGION_BASE:    base_address      = pwdata;
					default: ;
				endcase
			end
			if (item_valid && item_ready)
				scan_byte(item);
		end
		awaited = expected_q.size();
	end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the wildcard byte signature search core: a short directed
// run over wildcards, short regions, matches on the last byte, length
// clamping and address wrap, a back-pressure run, then random regions
// that mostly embed the configured signature among near-miss bytes, under
// random gaps on both channels and random register settings.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import wbss_pkg::*;

	localparam int     ITEM_TARGET    = 1800;
	localparam int     LATENCY        = 1;
	localparam int     HOLD_CYCLES    = 120;
	localparam int     PRESSURE_ITEMS = 40;
	localparam int     WINDOW_BYTES   = 16;
	localparam longint RUN_LIMIT_NS   = 8_000_000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        item_valid;
	logic        item_ready;
	item_t       item;
	logic        result_valid;
	logic        result_ready;
	result_t     result;
	int          mismatches;
	int          awaited;

	bit           calm;
	bit           hold_request;
	logic [127:0] sig_cfg;
	logic [4:0]   len_cfg;
	int           items_sent;

	wildcard_byte_signature_search_core DUT (.*);

	wbss_match_checker match_check (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic int sig_span();
		if (len_cfg == 5'd0)
			return 1;
		if (len_cfg > WINDOW_BYTES)
			return WINDOW_BYTES;
		return len_cfg;
	endfunction

	task automatic send_byte(input logic [7:0] value, input logic closes);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= '{data_byte: value, last_byte: closes};
		do @(posedge clk); while (!item_ready);
		items_sent++;
	endtask

	// drop valid and wait out every outstanding result plus the pipeline
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (awaited != 0) @(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic write_reg(input reg_index_t index, input logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input logic [63:0] low, high, input logic [4:0] length,
			input logic [63:0] base);
		settle();
		write_reg(REG_PATTERN_LOW, low);
		write_reg(REG_PATTERN_HIGH, high);
		write_reg(REG_PATTERN_LENGTH, 64'(length));
		write_reg(REG_REGION_BASE, base);
		sig_cfg = {high, low};
		len_cfg = length;
	endtask

	// hit_at < 0: filler only; spoil corrupts one signature position
	task automatic send_region(input int count, input int hit_at, input bit spoil);
		int         span;
		int         spoil_at;
		int         rel;
		logic [7:0] value;
		span = sig_span();
		spoil_at = $urandom_range(0, span - 1);
		for (int k = 0; k < count; k++) begin
			rel = k - hit_at;
			if (hit_at >= 0 && rel >= 0 && rel < span) begin
				value = sig_cfg[8*rel +: 8];
				if (value == WILDCARD_BYTE)
					value = 8'($urandom_range(0, 255));
				if (spoil && rel == spoil_at)
					value = value ^ (8'h01 << $urandom_range(0, 7));
			end else if ($urandom_range(0, 1) == 0) begin
				rel = $urandom_range(0, WINDOW_BYTES - 1);
				value = sig_cfg[8*rel +: 8];
			end else begin
				value = 8'($urandom_range(0, 255));
			end
			send_byte(value, k == count - 1);
		end
	endtask

	initial begin
		int stall_left;
		result_ready = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		logic [127:0] pat;
		logic [63:0]  base;
		logic [4:0]   length;
		int           span;
		int           count;
		int           kind;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		item = '0;
		calm = 1'b0;
		hold_request = 1'b0;
		sig_cfg = '0;
		len_cfg = 5'd1;
		items_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: single wildcard byte matches at once
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h55, 1'b1);

		// short region, then a mid-region match whose address wraps
		configure(64'h0000_0000_00FF_0001, 64'hFFFF_FFFF_FFFF_FFFF, 5'd3, '1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h7E, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);

		// zero length acts as one
		configure(64'h5A, 64'h0, 5'd0, 64'h1000);
		send_byte(8'h00, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'h5A, 1'b1);

		// oversized length saturates; match lands on the last byte
		configure(64'h0, 64'h8000_0000_0000_0000, 5'd31, 64'h8000_0000_0000_0000);
		send_region(WINDOW_BYTES, 0, 1'b0);

		// hold the result side while bytes keep coming
		configure({$urandom, $urandom}, {$urandom, $urandom}, 5'd1, {$urandom, $urandom});
		calm = 1'b1;
		hold_request = 1'b1;
		repeat (PRESSURE_ITEMS) send_byte(8'($urandom_range(0, 255)), 1'b1);
		calm = 1'b0;
		settle();

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 11) == 0) begin
				case ($urandom_range(0, 5))
					0: pat = '0;
					1: pat = '1;
					default: begin
						for (int i = 0; i < 2 * WINDOW_BYTES / 2; i++)
							pat[8*i +: 8] = ($urandom_range(0, 3) == 0) ?
								8'h00 : 8'($urandom_range(1, 255));
					end
				endcase
				length = ($urandom_range(0, 3) == 0) ?
					5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16));
				case ($urandom_range(0, 3))
					0: base = '0;
					1: base = '1;
					2: base = '1 - 64'($urandom_range(0, 40));
					default: base = {$urandom, $urandom};
				endcase
				configure(pat[63:0], pat[127:64], length, base);
			end
			if ($urandom_range(0, 7) == 0)
				calm = !calm;
			span = sig_span();
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				count = span + $urandom_range(0, 20);
				send_region(count, $urandom_range(0, count - span), kind == 5);
			end else if (kind < 8) begin
				send_region($urandom_range(1, 24), -1, 1'b0);
			end else if (kind == 8) begin
				send_region(1, -1, 1'b0);
			end else begin
				settle();
			end
		end

		settle();
		if (mismatches == 0 && awaited == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
